>>> sv/cdq_pkg.sv
package cdq_pkg;

    localparam int DATA_W   = 32;
    localparam int OCC_W    = 4;

    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_PUSH_FRONT = 2'd0;
    localparam action_t ACT_PUSH_REAR  = 2'd1;
    localparam action_t ACT_POP_FRONT  = 2'd2;
    localparam action_t ACT_POP_REAR   = 2'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

>>> sv/cdq_mem.sv
module cdq_mem #(
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  cdq_pkg::mem_ctl_t                       ctl,
    input  logic [$clog2(DEPTH)-1:0]                addr,
    input  logic [cdq_pkg::DATA_W-1:0]              wr_data,
    output logic [cdq_pkg::DATA_W-1:0]              rd_data
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/cdq_ctrl.sv
module cdq_ctrl #(
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  cdq_pkg::action_t                        action,
    output cdq_pkg::mem_ctl_t                       mem_ctl,
    output logic [$clog2(DEPTH)-1:0]                mem_addr,
    output logic                                    done,
    output cdq_pkg::status_t                        status,
    output logic                                    pop_ok,
    output logic [$clog2(DEPTH+1)-1:0]              count
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    logic             pop_ok_reg;
    status_t          status_reg, status_next;

    logic is_push;
    logic is_empty;
    logic is_full;
    logic push_ok;
    logic pop_go;
    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

    assign is_push  = ~action[1];
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);
    assign push_ok  = start & is_push & ~is_full;
    assign pop_go   = start & ~is_push & ~is_empty;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - 1'b1;
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? PTR_LAST : tail_reg - 1'b1;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        mem_addr    = head_reg;
        status_next = ST_DONE;
        if (start)
        begin
            unique case (action)
                ACT_PUSH_FRONT, ACT_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (is_empty)
                        begin
                            // first element always lands in slot zero
                            head_next = '0;
                            tail_next = '0;
                            mem_addr  = '0;
                        end
                        else if (action == ACT_PUSH_FRONT)
                        begin
                            head_next = head_dec;
                            mem_addr  = head_dec;
                        end
                        else
                        begin
                            tail_next = tail_inc;
                            mem_addr  = tail_inc;
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (action == ACT_POP_FRONT)
                        begin
                            mem_addr  = head_reg;
                            head_next = head_inc;
                        end
                        else
                        begin
                            mem_addr  = tail_reg;
                            tail_next = tail_dec;
                        end
                        // last element gone: pointers back to slot zero
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    assign mem_ctl.wr_en = push_ok;
    assign mem_ctl.rd_en = pop_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            done_reg   <= start;
            pop_ok_reg <= pop_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg <= status_next;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign pop_ok = pop_ok_reg;
    assign count  = count_reg;

endmodule

>>> sv/circular_deque.sv
// double-ended queue over a circular buffer of DEPTH 32-bit slots
//
// request channel: drive action and value with start high; the beat is taken
// at the rising edge where start is high and busy is low. busy stays low, so
// a new action may be issued every cycle.
// actions: push front, push rear, pop front, pop rear. a push into a full
// deque returns status full, a pop from an empty deque returns status empty;
// neither changes anything.
// result channel: one beat per action, in the cycle after it was taken, shown
// for exactly one cycle with done high: status, popped_value (zero unless a
// pop succeeded) and occupancy after the action (count modulo 16).
// throughput is one action per cycle: each action does a single access to the
// one-port slot memory, whose read data is registered.
// the receiver cannot stall; results are not held.
// reset clears pointers and count, so the deque starts empty; slot contents
// are left as they are and only slots written by a push are ever read.
module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cdq_pkg::action_t                    action,
    input  logic signed [cdq_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output cdq_pkg::status_t                    status,
    output logic signed [cdq_pkg::DATA_W-1:0]   popped_value,
    output logic [cdq_pkg::OCC_W-1:0]           occupancy
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mem_ctl_t          mem_ctl;
    logic [PTR_W-1:0]  mem_addr;
    logic [DATA_W-1:0] rd_data;
    logic              pop_ok;
    logic [CNT_W-1:0]  count;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (action),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .done     (done),
        .status   (status),
        .pop_ok   (pop_ok),
        .count    (count)
    );

    cdq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (DATA_W'(value)),
        .rd_data (rd_data)
    );

    // busy is tied low: no action ever holds off the next one
    assign busy         = 1'b0;
    assign popped_value = pop_ok ? $signed(rd_data) : '0;
    assign occupancy    = OCC_W'(count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> count == CNT_W'(DEPTH))
        else $error("full status while deque not full");

    a_empty_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> count == '0)
        else $error("empty status while deque holds elements");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok |-> done && status == ST_DONE)
        else $error("pop data without a completed pop beat");

    a_no_access_on_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en || mem_ctl.rd_en |=> done && status == ST_DONE)
        else $error("slot access for a refused action");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cdq_pkg::*;

    localparam int DEPTH       = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_ITEMS  = 150;
    localparam int RANDOM_ITEMS = 1780;

    typedef struct {
        action_t                   act;
        logic signed [DATA_W-1:0]  val;
    } deque_req_t;

    typedef struct {
        status_t                   status;
        logic signed [DATA_W-1:0]  popped;
        logic [OCC_W-1:0]          occupancy;
    } deque_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    action_t                    action = ACT_PUSH_FRONT;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       busy;
    logic                       done;
    status_t                    status;
    logic signed [DATA_W-1:0]   popped_value;
    logic [OCC_W-1:0]           occupancy;

    deque_req_t     deque_requests[$];
    deque_reply_t   predicted_replies[$];

    // shadow copy of the deque contents
    logic signed [DATA_W-1:0]   shadow_slots[DEPTH];
    int unsigned                shadow_head = 0;
    int unsigned                shadow_tail = 0;
    int unsigned                shadow_count = 0;

    int unsigned    mismatches = 0;
    int unsigned    gap_left;
    int unsigned    gap_pct;
    int unsigned    stall_cycles = 0;
    deque_req_t     next_req;

    circular_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .status      (status),
        .popped_value(popped_value),
        .occupancy   (occupancy)
    );

    always #5 clk = ~clk;

    task automatic apply_deque_action(input action_t act, input logic signed [DATA_W-1:0] val);
        deque_reply_t r;
        r.status = ST_DONE;
        r.popped = '0;
        if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                if (shadow_count == 0) begin
                    shadow_head = 0;
                    shadow_tail = 0;
                    shadow_slots[0] = val;
                end
                else if (act == ACT_PUSH_FRONT) begin
                    shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                    shadow_slots[shadow_head] = val;
                end
                else begin
                    shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
                    shadow_slots[shadow_tail] = val;
                end
                shadow_count++;
            end
        end
        else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                if (act == ACT_POP_FRONT) begin
                    r.popped = shadow_slots[shadow_head];
                    shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
                end
                else begin
                    r.popped = shadow_slots[shadow_tail];
                    shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
                end
                shadow_count--;
                if (shadow_count == 0) begin
                    shadow_head = 0;
                    shadow_tail = 0;
                end
            end
        end
        r.occupancy = shadow_count[OCC_W-1:0];
        predicted_replies.push_back(r);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(input action_t act, input logic signed [DATA_W-1:0] val);
        deque_req_t q;
        q.act = act;
        q.val = val;
        deque_requests.push_back(q);
    endtask

    // driver: one beat per accepted request, random idle bursts except near the end
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
            gap_pct  <= 10;
        end
        else begin
            if (start && !busy)
                apply_deque_action(action, value);
            if (start && busy) begin
                // hold the beat until it is taken
            end
            else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (deque_requests.size() > TAIL_ITEMS && $urandom_range(0, 99) < gap_pct) begin
                gap_left <= $urandom_range(0, 17);
                start    <= 1'b0;
            end
            else if (deque_requests.size() != 0) begin
                next_req = deque_requests.pop_front();
                action   <= next_req.act;
                value    <= next_req.val;
                start    <= 1'b1;
            end
            else begin
                start <= 1'b0;
            end
            if ($urandom_range(0, 127) == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct <= 0;
                    1:       gap_pct <= 5;
                    default: gap_pct <= 30;
                endcase
            end
        end
    end

    // monitor: every done beat is checked against the oldest prediction
    always @(posedge clk) begin
        deque_reply_t want;
        if (rst_n && done) begin
            if (predicted_replies.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: status %0d popped %0d occupancy %0d",
                             status, popped_value, occupancy);
                mismatches++;
            end
            else begin
                want = predicted_replies.pop_front();
                if (status !== want.status || popped_value !== want.popped ||
                    occupancy !== want.occupancy) begin
                    if (mismatches < 10)
                        $display("mismatch: status %0d/%0d popped %0d/%0d occupancy %0d/%0d",
                                 status, want.status, popped_value, want.popped,
                                 occupancy, want.occupancy);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned issued;
        int unsigned seg_len;
        int unsigned push_pct;
        int unsigned total_bad;
        logic signed [DATA_W-1:0] fill_vals[8];

        // directed: empty pops, single-element round trips, fill past full, drain
        add_request(ACT_POP_FRONT, 32'sd5);
        add_request(ACT_POP_REAR, -32'sd5);
        add_request(ACT_PUSH_FRONT, 32'sh8000_0000);
        add_request(ACT_POP_REAR, '0);
        add_request(ACT_PUSH_REAR, 32'sh7fff_ffff);
        add_request(ACT_POP_FRONT, '0);
        fill_vals = '{-32'sd1, 32'sd0, 32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa,
                      32'sh8000_0000, 32'sh7fff_ffff, 32'sh1234_5678};
        foreach (fill_vals[i])
            add_request((i % 2 == 0) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, fill_vals[i]);
        add_request(ACT_PUSH_FRONT, 32'sd99);
        add_request(ACT_PUSH_REAR, -32'sd99);
        for (int i = 0; i < DEPTH; i++)
            add_request((i % 2 == 0) ? ACT_POP_FRONT : ACT_POP_REAR, 32'shffff_ffff);
        add_request(ACT_POP_FRONT, '0);

        // random: segments biased toward filling, draining or churning
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 80);
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            for (int i = 0; i < seg_len; i++) begin
                if ($urandom_range(0, 99) < push_pct)
                    add_request($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT,
                                pick_value());
                else
                    add_request($urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT,
                                pick_value());
            end
            issued += seg_len;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (deque_requests.size() != 0 || start)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        total_bad = mismatches + predicted_replies.size();
        if (total_bad == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
